>>> hdl/ksle_pkg.sv
// ----------------------------------------------------------------------------
// ksle_pkg
// Shared types, scan codes and key tables for the scan-code line editor.
// ----------------------------------------------------------------------------
package ksle_pkg;

  // default line capacity
  localparam int LINE_CAPACITY = 256;

  // command flag on the input side
  localparam logic CMD_SCAN_CODE = 1'b0;
  localparam logic CMD_NEW_LINE  = 1'b1;

  // edit action on the output side
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_ERASE  = 1'b1;

  // set 1 scan codes with a special meaning
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;

  // character codes
  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0] CHAR_FIRST     = 8'h20;
  localparam logic [7:0] CHAR_LAST      = 8'h7E;

  localparam int KEY_TABLE_SIZE = 64;

  // german layout, no modifier
  localparam logic [7:0] PLAIN_KEYS [KEY_TABLE_SIZE] = '{
    8'd0,   8'd27,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
    8'd55,  8'd56,  8'd57,  8'd48,  8'd223, 8'd180, 8'd8,   8'd9,
    8'd113, 8'd119, 8'd101, 8'd114, 8'd116, 8'd122, 8'd117, 8'd105,
    8'd111, 8'd112, 8'd252, 8'd43,  8'd10,  8'd0,   8'd97,  8'd115,
    8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd246,
    8'd228, 8'd35,  8'd0,   8'd60,  8'd121, 8'd120, 8'd99,  8'd118,
    8'd98,  8'd110, 8'd109, 8'd44,  8'd46,  8'd45,  8'd0,   8'd42,
    8'd0,   8'd32,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };

  // german layout, shift or caps lock
  localparam logic [7:0] SHIFTED_KEYS [KEY_TABLE_SIZE] = '{
    8'd0,   8'd27,  8'd33,  8'd34,  8'd167, 8'd36,  8'd37,  8'd38,
    8'd47,  8'd40,  8'd41,  8'd61,  8'd63,  8'd96,  8'd8,   8'd9,
    8'd81,  8'd87,  8'd69,  8'd82,  8'd84,  8'd90,  8'd85,  8'd73,
    8'd79,  8'd80,  8'd220, 8'd42,  8'd10,  8'd0,   8'd65,  8'd83,
    8'd68,  8'd70,  8'd71,  8'd72,  8'd74,  8'd75,  8'd76,  8'd214,
    8'd196, 8'd39,  8'd0,   8'd62,  8'd89,  8'd88,  8'd67,  8'd86,
    8'd66,  8'd78,  8'd77,  8'd59,  8'd58,  8'd95,  8'd0,   8'd42,
    8'd0,   8'd32,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };

  // classification of one make code
  typedef struct packed {
    logic [7:0] ch;
    logic       backspace;
    logic       printable;
  } key_info_t;

endpackage

>>> hdl/keyboard_scancode_line_editor.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_line_editor
// Set 1 scan codes in, line edits (append or erase at a position) out.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tdata: scan_code, tuser: command
//  m_axis   | out | m_axis_tvalid/tready    | tdata: typed_char, line_index,
//           |     |                         | tuser: edit_action
//
//  one transfer per cycle in both directions unless the output stalls; a scan code
//  reaches the output through the input register, then the result register
//  rst clears shift, caps, the line position and both valid flags
//  a stalled output holds its result; the input register keeps taking
//  transfers as long as its item can move on in the same cycle
//  codes that cause no result still pass through the input register
//
module keyboard_scancode_line_editor #(
  parameter int LINE_CAPACITY = ksle_pkg::LINE_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] scan_code
  input  logic        s_axis_tuser,   // [0] command

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] typed_char, [15:8] line_index
  output logic        m_axis_tuser    // [0] edit_action
);

  // position at which appends stop, capped by the 8-bit position
  localparam int LINE_LIMIT_INT = (LINE_CAPACITY - 1 > 255) ? 255 : LINE_CAPACITY - 1;
  localparam logic [7:0] LINE_LIMIT = 8'(LINE_LIMIT_INT);

  // input register
  logic       in_valid;
  logic       in_command;
  logic [7:0] in_code;

  // editor state
  logic       shift_held;
  logic       caps_on;
  logic [7:0] line_position;

  // result register
  logic       out_valid;
  logic       out_action;
  logic [7:0] out_char;
  logic [7:0] out_index;

  // decode results
  ksle_pkg::key_info_t key_info;
  logic       advance;
  logic       emit;
  logic       emit_action;
  logic [7:0] emit_char;
  logic [7:0] emit_index;
  logic       shift_held_next;
  logic       caps_on_next;
  logic [7:0] line_position_next;

  ksle_keymap u_keymap (
    .shifted (shift_held | caps_on),
    .code    (in_code[6:0]),
    .info    (key_info)
  );

  // the held item moves on when the result register is free or drains
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // state update and result for the held item
  always_comb begin
    shift_held_next    = shift_held;
    caps_on_next       = caps_on;
    line_position_next = line_position;
    emit               = 1'b0;
    emit_action        = ksle_pkg::ACT_APPEND;
    emit_char          = key_info.ch;
    emit_index         = line_position;
    priority if (in_command == ksle_pkg::CMD_NEW_LINE) begin
      line_position_next = 8'd0;
    end else if (in_code == ksle_pkg::SC_LSHIFT_MAKE
              || in_code == ksle_pkg::SC_RSHIFT_MAKE) begin
      shift_held_next = 1'b1;
    end else if (in_code == ksle_pkg::SC_LSHIFT_BREAK
              || in_code == ksle_pkg::SC_RSHIFT_BREAK) begin
      shift_held_next = 1'b0;
    end else if (in_code == ksle_pkg::SC_CAPS_MAKE) begin
      caps_on_next = !caps_on;
    end else if (in_code[7]) begin
      // other break codes
    end else if (key_info.backspace) begin
      if (line_position != 8'd0) begin
        line_position_next = line_position - 8'd1;
        emit               = 1'b1;
        emit_action        = ksle_pkg::ACT_ERASE;
        emit_char          = 8'd0;
        emit_index         = line_position - 8'd1;
      end
    end else if (key_info.printable) begin
      if (line_position < LINE_LIMIT) begin
        line_position_next = line_position + 8'd1;
        emit               = 1'b1;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_command <= s_axis_tuser;
      in_code    <= s_axis_tdata;
    end
  end

  // editor state
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held    <= 1'b0;
      caps_on       <= 1'b0;
      line_position <= 8'd0;
    end else if (advance) begin
      shift_held    <= shift_held_next;
      caps_on       <= caps_on_next;
      line_position <= line_position_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && emit) begin
      out_action <= emit_action;
      out_char   <= emit_char;
      out_index  <= emit_index;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_index, out_char};
  assign m_axis_tuser  = out_action;

  // the position never passes the append limit
  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    line_position <= LINE_LIMIT)
    else $error("line position past the append limit");

  // an erase carries no character
  a_erase_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ksle_pkg::ACT_ERASE)
      |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("erase result with a nonzero character");

  // an appended character is printable
  a_append_printable: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ksle_pkg::ACT_APPEND)
      |-> (m_axis_tdata[7:0] >= ksle_pkg::CHAR_FIRST
           && m_axis_tdata[7:0] <= ksle_pkg::CHAR_LAST))
    else $error("appended character outside the printable range");

  // an append steps the position forward by one and reports the old position
  a_append_step: assert property (@(posedge clk) disable iff (rst)
    (advance && emit && emit_action == ksle_pkg::ACT_APPEND)
      |=> (line_position == $past(line_position) + 8'd1
           && m_axis_tdata[15:8] == $past(line_position)))
    else $error("append did not advance the line position");

  // an erase reports the new position
  a_erase_step: assert property (@(posedge clk) disable iff (rst)
    (advance && emit && emit_action == ksle_pkg::ACT_ERASE)
      |=> (m_axis_tdata[15:8] == line_position))
    else $error("erase index differs from the new line position");

endmodule

>>> hdl/ksle_keymap.sv
// ----------------------------------------------------------------------------
// ksle_keymap
// Maps a make code through the plain or shifted table and classifies it.
// ----------------------------------------------------------------------------
module ksle_keymap (
  input  logic                  shifted,
  input  logic [6:0]            code,
  output ksle_pkg::key_info_t   info
);

  logic [7:0] ch;

  // table lookup, codes past the table map to nothing
  always_comb begin
    if (code[6]) begin
      ch = 8'd0;
    end else if (shifted) begin
      ch = ksle_pkg::SHIFTED_KEYS[code[5:0]];
    end else begin
      ch = ksle_pkg::PLAIN_KEYS[code[5:0]];
    end
  end

  // classify the character
  assign info.ch        = ch;
  assign info.backspace = (ch == ksle_pkg::CHAR_BACKSPACE);
  assign info.printable = (ch >= ksle_pkg::CHAR_FIRST) && (ch <= ksle_pkg::CHAR_LAST);

endmodule
